### sv/dq_pkg.sv
// Shared constants, types and ring index helpers for the deque core.
package dq_pkg;

    // Ring storage depth and derived widths
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int CAP_W  = 11;
    localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
    localparam logic [CMP_W-1:0] DEPTH_EXT = CMP_W'(DEPTH);
    localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

    // Operation codes
    typedef enum logic [2:0] {
        OP_QUERY      = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_REAR  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_REAR   = 3'd4
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic read;
        logic load_out;
    } dq_cmd_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

endpackage

### sv/dq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                          rdata_a,
    output logic [WIDTH-1:0]                          rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Register both read ports
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### sv/dq_ctrl.sv
// Controller state machine: sequences accept, execute, read and result load.
module dq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output dq_pkg::dq_cmd_t cmd
);
    import dq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_READ = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free or being drained
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### sv/dq_datapath.sv
// Datapath: ring pointers, entry count, capacity, entry RAM and result register.
module dq_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dq_pkg::dq_cmd_t            cmd,
    input  logic [2:0]                 s_operation,
    input  logic signed [31:0]         s_value,
    input  logic                       cfg_valid,
    input  logic [dq_pkg::CAP_W-1:0]   cfg_capacity,
    output logic                       m_success,
    output logic signed [31:0]         m_front_value,
    output logic signed [31:0]         m_rear_value,
    output logic                       m_is_empty,
    output logic                       m_is_full
);
    import dq_pkg::*;

    op_t               op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic              ok_reg, ok_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] rdata_front, rdata_rear;

    logic [CMP_W-1:0]  cap_ext, limit_ext, count_ext;
    logic              has_room, is_empty_now;

    logic              success_reg, is_empty_reg, is_full_reg;
    logic [DATA_W-1:0] front_reg, rear_reg;

    // Effective limit saturates at the ring depth
    assign cap_ext      = CMP_W'(capacity_reg);
    assign limit_ext    = (cap_ext > DEPTH_EXT) ? DEPTH_EXT : cap_ext;
    assign count_ext    = CMP_W'(count_reg);
    assign has_room     = (count_ext < limit_ext);
    assign is_empty_now = (count_reg == '0);

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_capacity;
        end
    end

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= op_t'(s_operation);
            value_reg <= s_value;
        end
    end

    // Decode the operation against the current pointers
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ok_next    = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = tail_reg;
        case (op_reg)
            OP_QUERY: begin
                ok_next = 1'b1;
            end
            OP_PUSH_FRONT: begin
                if (has_room) begin
                    head_next  = ring_prev(head_reg);
                    ram_waddr  = ring_prev(head_reg);
                    ram_we     = cmd.exec;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_PUSH_REAR: begin
                if (has_room) begin
                    tail_next  = ring_next(tail_reg);
                    ram_waddr  = tail_reg;
                    ram_we     = cmd.exec;
                    count_next = count_reg + 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (!is_empty_now) begin
                    head_next  = ring_next(head_reg);
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                end
            end
            OP_POP_REAR: begin
                if (!is_empty_now) begin
                    tail_next  = ring_prev(tail_reg);
                    count_next = count_reg - 1'b1;
                    ok_next    = 1'b1;
                end
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            ok_reg <= ok_next;
        end
    end

    // Entry store: front at head, rear one slot behind tail
    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (value_reg),
        .re      (cmd.read),
        .raddr_a (head_reg),
        .raddr_b (ring_prev(tail_reg)),
        .rdata_a (rdata_front),
        .rdata_b (rdata_rear)
    );

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            success_reg  <= ok_reg;
            is_empty_reg <= is_empty_now;
            is_full_reg  <= !has_room;
            front_reg    <= is_empty_now ? EMPTY_MARK : rdata_front;
            rear_reg     <= is_empty_now ? EMPTY_MARK : rdata_rear;
        end
    end

    assign m_success     = success_reg;
    assign m_front_value = front_reg;
    assign m_rear_value  = rear_reg;
    assign m_is_empty    = is_empty_reg;
    assign m_is_full     = is_full_reg;

endmodule

### sv/bounded_double_ended_queue_core.sv
// Top level of the bounded double-ended queue core.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one operation and a value:
//   query, push front, push rear, pop front or pop rear. Each item returns
//   one result on the m_ channel: success flag, front and rear values after
//   the operation (-1 when empty), and empty and full flags.
//   Configuration channel (cfg_valid/cfg_ready) writes the capacity; it is
//   always ready. It must be written only while no item is in flight; the
//   block itself does not enforce this. The controller steps each item through
//   accept, execute (pointer update and entry write), RAM read of front and
//   rear, and result load, and accepts no new item before the result load.
//   A finished result waits in the output register while the next item is
//   accepted; if the receiver stalls, the following item holds in the last
//   step until the output register drains.
//   Reset (aresetn low, synchronous) empties the deque, clears pointers and
//   sets capacity to 1024. Entry contents are not cleared; only written
//   entries are ever reported.
module bounded_double_ended_queue_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic signed [31:0]       s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_success,
    output logic signed [31:0]       m_front_value,
    output logic signed [31:0]       m_rear_value,
    output logic                     m_is_empty,
    output logic                     m_is_full,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [dq_pkg::CAP_W-1:0] cfg_capacity
);
    import dq_pkg::*;

    dq_cmd_t cmd;

    // Capacity writes are taken at any time
    assign cfg_ready = 1'b1;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dq_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .cfg_valid     (cfg_valid),
        .cfg_capacity  (cfg_capacity),
        .m_success     (m_success),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

endmodule

### dv/bounded_double_ended_queue_core_tb.sv
// Self-checking testbench for the bounded double-ended queue core.
module bounded_double_ended_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    // Operation codes the core leaves unused, capacity extremes and value extremes
    localparam logic [2:0]        OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]        OP_SPARE_MID   = 3'd6;
    localparam logic [2:0]        OP_SPARE_LAST  = 3'd7;
    localparam logic [CAP_W-1:0]  CAP_NONE       = '0;
    localparam logic [CAP_W-1:0]  CAP_FIELD_MAX  = '1;
    localparam logic [DATA_W-1:0] VAL_MIN        = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX        = 32'h7FFF_FFFF;
    localparam int                SETTLE_CYCLES  = 8;
    localparam int                CYCLE_LIMIT    = 600_000;

    typedef struct packed {
        logic              success;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] rear;
        logic              empty;
        logic              full;
    } deque_status_t;

    typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [2:0]        op;
        logic [DATA_W-1:0] data;
        logic              has_want;
        deque_status_t     want;
    } script_row_t;

    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [2:0]               s_operation   = OP_QUERY;
    logic signed [31:0]       s_value       = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic                     m_success;
    logic signed [31:0]       m_front_value;
    logic signed [31:0]       m_rear_value;
    logic                     m_is_empty;
    logic                     m_is_full;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_capacity  = CAP_RESET;

    // Typed expectation travelling with the item on the input channel
    logic                     drive_has_want = 1'b0;
    deque_status_t            drive_want     = '0;

    // Shadow deque state
    logic [DATA_W-1:0]        ring_mem [DEPTH];
    logic [IDX_W-1:0]         model_head = '0;
    logic [IDX_W-1:0]         model_tail = '0;
    int unsigned              model_fill = 0;
    logic [CAP_W-1:0]         model_cap  = CAP_RESET;

    deque_status_t            status_q [$];
    script_row_t              script [$];

    int unsigned              fail_count   = 0;
    int unsigned              cycle_count  = 0;
    int unsigned              ops_accepted = 0;
    int unsigned              ops_refused  = 0;
    int unsigned              results_seen = 0;
    int unsigned              full_seen    = 0;
    int unsigned              peak_fill    = 0;
    int unsigned              cap_writes   = 0;
    int unsigned              burst_left   = 0;
    int unsigned              stall_left   = 0;
    int unsigned              stall_pct    = 0;

    bounded_double_ended_queue_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_success     (m_success),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_capacity  (cfg_capacity)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Ring index stepping, modulo the depth
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return IDX_W'((int'(i) + 1) % DEPTH);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return IDX_W'((int'(i) + DEPTH - 1) % DEPTH);
    endfunction

    // Apply one operation to the shadow deque and return the status it reports
    function automatic deque_status_t apply_op(input logic [2:0] op,
                                               input logic [DATA_W-1:0] v);
        int unsigned   lim;
        deque_status_t r;
        lim = (model_cap > DEPTH) ? DEPTH : int'(model_cap);
        r = '0;
        case (op)
            OP_QUERY: begin
                r.success = 1'b1;
            end
            OP_PUSH_FRONT: begin
                if (model_fill < lim) begin
                    model_head = wrap_dec(model_head);
                    ring_mem[model_head] = v;
                    model_fill++;
                    r.success = 1'b1;
                end
            end
            OP_PUSH_REAR: begin
                if (model_fill < lim) begin
                    ring_mem[model_tail] = v;
                    model_tail = wrap_inc(model_tail);
                    model_fill++;
                    r.success = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (model_fill != 0) begin
                    model_head = wrap_inc(model_head);
                    model_fill--;
                    r.success = 1'b1;
                end
            end
            OP_POP_REAR: begin
                if (model_fill != 0) begin
                    model_tail = wrap_dec(model_tail);
                    model_fill--;
                    r.success = 1'b1;
                end
            end
            default: begin
                r.success = 1'b0;
            end
        endcase
        if (model_fill != 0) begin
            r.front = ring_mem[model_head];
            r.rear  = ring_mem[wrap_dec(model_tail)];
        end else begin
            r.front = EMPTY_MARK;
            r.rear  = EMPTY_MARK;
        end
        r.empty = (model_fill == 0);
        r.full  = (model_fill >= lim);
        return r;
    endfunction

    function automatic script_row_t item_row(input logic [2:0] op,
                                             input logic [DATA_W-1:0] v);
        script_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.op   = op;
        row.data = v;
        return row;
    endfunction

    function automatic script_row_t checked_row(input logic [2:0] op,
                                                input logic [DATA_W-1:0] v,
                                                input logic ok,
                                                input logic [DATA_W-1:0] fv,
                                                input logic [DATA_W-1:0] rv,
                                                input logic emp,
                                                input logic ful);
        script_row_t row;
        row = item_row(op, v);
        row.has_want = 1'b1;
        row.want     = '{ok, fv, rv, emp, ful};
        return row;
    endfunction

    function automatic script_row_t cap_row(input logic [CAP_W-1:0] c);
        script_row_t row;
        row = '0;
        row.kind = ROW_CAPACITY;
        row.data = DATA_W'(c);
        return row;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Track handshakes: capacity writes, accepted items, returned results
    always @(posedge aclk) begin : scoreboard
        deque_status_t want;
        deque_status_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                model_cap = cfg_capacity;
                cap_writes++;
            end
            if (s_valid && s_ready) begin
                want = apply_op(s_operation, s_value);
                if (drive_has_want)
                    want = drive_want;
                status_q.push_back(want);
                ops_accepted++;
                if (!want.success)
                    ops_refused++;
                if (model_fill > peak_fill)
                    peak_fill = model_fill;
            end
            if (m_valid && m_ready) begin
                got = '{m_success, m_front_value, m_rear_value, m_is_empty, m_is_full};
                results_seen++;
                if (status_q.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    if (want.full)
                        full_seen++;
                    report_field("success", 32'(want.success), 32'(got.success));
                    report_field("front_value", want.front, got.front);
                    report_field("rear_value", want.rear, got.rear);
                    report_field("is_empty", 32'(want.empty), 32'(got.empty));
                    report_field("is_full", 32'(want.full), 32'(got.full));
                end
            end
        end
    end

    // Stall the result channel in segments of random length and density
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(10, 300);
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        stall_left--;
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, status_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drop valid and hold until every outstanding item has returned
    task automatic quiesce();
        s_valid <= 1'b0;
        do @(posedge aclk); while (status_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        quiesce();
        cfg_valid    <= 1'b1;
        cfg_capacity <= c;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Present one item, with a random gap at burst boundaries, and wait for accept
    task automatic send_op(input logic [2:0] op, input logic [DATA_W-1:0] v,
                           input logic has_want, input deque_status_t want);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 11) == 0) begin
                quiesce();
            end else begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_value        <= v;
        drive_has_want <= has_want;
        drive_want     <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random items: push and pop weights in percent, the rest queries and unused codes
    task automatic run_ops(input int unsigned n, input int unsigned push_w,
                           input int unsigned pop_w);
        int unsigned pick;
        logic [2:0]  op;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < push_w)
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            else if (pick < push_w + pop_w)
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
            else if ($urandom_range(0, 1))
                op = OP_QUERY;
            else
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            send_op(op, pick_value(), 1'b0, '0);
        end
    endtask

    initial begin
        script = '{
            // empty deque straight out of reset
            checked_row(OP_QUERY, '0, 1'b1, EMPTY_MARK, EMPTY_MARK, 1'b1, 1'b0),
            checked_row(OP_POP_FRONT, '0, 1'b0, EMPTY_MARK, EMPTY_MARK, 1'b1, 1'b0),
            checked_row(OP_POP_REAR, '0, 1'b0, EMPTY_MARK, EMPTY_MARK, 1'b1, 1'b0),
            checked_row(OP_SPARE_FIRST, VAL_MAX, 1'b0, EMPTY_MARK, EMPTY_MARK, 1'b1, 1'b0),
            // value extremes at both ends, head wraps below slot zero
            checked_row(OP_PUSH_FRONT, VAL_MIN, 1'b1, VAL_MIN, VAL_MIN, 1'b0, 1'b0),
            checked_row(OP_PUSH_REAR, VAL_MAX, 1'b1, VAL_MIN, VAL_MAX, 1'b0, 1'b0),
            item_row(OP_PUSH_FRONT, '0),
            item_row(OP_PUSH_REAR, '1),
            item_row(OP_SPARE_LAST, VAL_MAX),
            item_row(OP_POP_FRONT, '0),
            item_row(OP_POP_REAR, '0),
            // limit dropped below the count keeps the entries
            cap_row(CAP_W'(1)),
            item_row(OP_PUSH_REAR, 32'd7),
            item_row(OP_SPARE_MID, '0),
            item_row(OP_POP_FRONT, '0),
            item_row(OP_PUSH_FRONT, 32'd5),
            item_row(OP_POP_REAR, '0),
            // zero capacity: empty and full together
            cap_row(CAP_NONE),
            checked_row(OP_PUSH_FRONT, 32'd9, 1'b0, EMPTY_MARK, EMPTY_MARK, 1'b1, 1'b1),
            checked_row(OP_QUERY, '0, 1'b1, EMPTY_MARK, EMPTY_MARK, 1'b1, 1'b1),
            // capacity above the depth saturates
            cap_row(CAP_FIELD_MAX),
            item_row(OP_PUSH_REAR, 32'h5555_5555),
            item_row(OP_PUSH_FRONT, 32'hAAAA_AAAA),
            item_row(OP_QUERY, '0)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (script[i]) begin
            if (script[i].kind == ROW_CAPACITY)
                write_capacity(script[i].data[CAP_W-1:0]);
            else
                send_op(script[i].op, script[i].data, script[i].has_want, script[i].want);
        end

        // Small limits: hit full and empty often
        repeat (4) begin
            write_capacity(CAP_W'($urandom_range(1, 8)));
            run_ops(36, 45, 40);
        end
        write_capacity(CAP_NONE);
        run_ops(20, 50, 30);

        // Fill the whole ring, then keep pushing against full
        write_capacity(CAP_FIELD_MAX);
        while (model_fill < DEPTH)
            run_ops(32, 100, 0);
        run_ops(30, 60, 10);

        // Lower the limit below the count, then pop back under it
        write_capacity(CAP_W'($urandom_range(960, 1016)));
        run_ops(30, 50, 20);
        while (model_fill >= model_cap)
            run_ops(16, 4, 92);
        run_ops(30, 30, 60);

        write_capacity(CAP_W'($urandom_range(1, CAP_FIELD_MAX)));
        run_ops(50, 40, 40);
        write_capacity(CAP_RESET);
        run_ops(30, 45, 40);

        quiesce();
        $display("Ran %0d operations (%0d refused or unused) and checked %0d results.",
                 ops_accepted, ops_refused, results_seen);
        $display("Wrote capacity %0d times; peak occupancy %0d of %0d, full on %0d results.",
                 cap_writes, peak_fill, DEPTH, full_seen);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
